// ===== hw/rtl/bfid_pkg.sv =====
// Shared widths, register indexes and channel count for the box filter downscaler.
`timescale 1ns / 1ps
`default_nettype none

package bfid_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = 32;
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int NUM_CH    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [PIX_W-1:0] pix_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bfid_divider.sv =====
// Restoring unsigned divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module bfid_divider (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [bfid_pkg::DIV_W-1:0]   dividend,
    input  wire logic [bfid_pkg::DIV_W-1:0]   divisor,
    output logic                              busy,
    output logic                              done,
    output logic [bfid_pkg::DIV_W-1:0]        quotient
);

    localparam int DW = bfid_pkg::DIV_W;

    logic [DW:0]                        rem_reg;
    logic [DW:0]                        rem_next;
    logic [DW:0]                        rem_shift;
    logic [DW-1:0]                      quo_reg;
    logic [DW-1:0]                      quo_next;
    logic [DW-1:0]                      den_reg;
    logic [bfid_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;

    always_comb
    begin
        rem_shift = {rem_reg[DW-1:0], quo_reg[DW-1]};
        if (rem_shift >= {1'b0, den_reg})
        begin
            rem_next = rem_shift - {1'b0, den_reg};
            quo_next = {quo_reg[DW-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_shift;
            quo_next = {quo_reg[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == bfid_pkg::DIV_CNT_W'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + bfid_pkg::DIV_CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/box_filter_image_downscaler.sv =====
// Top level of the area-averaging RGBA image downscaler with its column sum memory.
// An item that changes no bin bound passes through the read, modify and advance states; each
// bin bound that changes is then computed by a bit-serial divider before the next item.
// An item that closes a bin also runs the four channel divisions in parallel.
// Reset clears the control state and the pixel and sum registers; the column sum memory
// is never cleared, since the first row of every bin row overwrites its entries before use.
`timescale 1ns / 1ps
`default_nettype none

module box_filter_image_downscaler #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [bfid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bfid_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [bfid_pkg::PIX_W-1:0]          in_red,
    input  wire logic [bfid_pkg::PIX_W-1:0]          in_green,
    input  wire logic [bfid_pkg::PIX_W-1:0]          in_blue,
    input  wire logic [bfid_pkg::PIX_W-1:0]          in_alpha,
    input  wire logic                                start_of_frame,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [bfid_pkg::PIX_W-1:0]               out_red,
    output logic [bfid_pkg::PIX_W-1:0]               out_green,
    output logic [bfid_pkg::PIX_W-1:0]               out_blue,
    output logic [bfid_pkg::PIX_W-1:0]               out_alpha,
    output logic                                     end_of_row,
    output logic                                     end_of_frame
);

    localparam int CWW = $clog2(MAX_WIDTH + 1);
    localparam int RWW = $clog2(MAX_HEIGHT + 1);
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int NW  = CWW + RWW;
    localparam int BW  = 2 * RWW > 2 * CWW ? 2 * RWW : 2 * CWW;
    localparam int DW  = bfid_pkg::DIV_W;
    localparam int SW  = bfid_pkg::SUM_W;
    localparam int NCH = bfid_pkg::NUM_CH;

    typedef enum logic [3:0] {
        S_IDLE,
        S_JOB,
        S_BDIV,
        S_BWAIT,
        S_READ,
        S_MOD,
        S_ODIV,
        S_OWAIT,
        S_OPUT,
        S_ADV
    } state_t;

    state_t                         state_reg;

    logic [bfid_pkg::CFG_W-1:0]     sw_reg;
    logic [bfid_pkg::CFG_W-1:0]     sh_reg;
    logic [bfid_pkg::CFG_W-1:0]     tw_reg;
    logic [bfid_pkg::CFG_W-1:0]     th_reg;

    logic [CWW-1:0]                 sc_reg;
    logic [CWW-1:0]                 tc_reg;
    logic [CWW-1:0]                 cbs_reg;
    logic [CWW-1:0]                 cbe_reg;
    logic [RWW-1:0]                 sr_reg;
    logic [RWW-1:0]                 tr_reg;
    logic [RWW-1:0]                 rbs_reg;
    logic [RWW-1:0]                 rbe_reg;

    logic                           restart_req_reg;
    logic                           pend_row_reg;
    logic                           pend_col_reg;
    logic                           cont_read_reg;
    logic                           job_row_reg;
    logic                           first_row_reg;
    logic                           last_row_reg;

    bfid_pkg::pix_t                 pix_reg [NCH];
    bfid_pkg::sum_t                 bin_sum_reg [NCH];
    logic [DW-1:0]                  prod_reg;
    logic [DW-1:0]                  bden_reg;
    logic [DW-1:0]                  n_reg;

    logic                           out_valid_reg;
    bfid_pkg::pix_t                 out_pix_reg [NCH];
    logic                           eor_reg;
    logic                           eof_reg;

    logic [NCH*SW-1:0]              mem [MAX_WIDTH];
    logic [NCH*SW-1:0]              mem_rdata_reg;
    logic [NCH*SW-1:0]              mem_wdata;
    logic [AW-1:0]                  mem_addr;

    logic [CWW-1:0]                 eff_w;
    logic [RWW-1:0]                 eff_h;
    logic [CWW-1:0]                 eff_tw;
    logic [RWW-1:0]                 eff_th;

    bfid_pkg::sum_t                 col_sum [NCH];
    logic [NW-1:0]                  n_full;
    logic [BW-1:0]                  col_prod;
    logic [BW-1:0]                  row_prod;
    logic [CWW-1:0]                 sc_inc;
    logic [RWW-1:0]                 sr_inc;

    logic                           div_start;
    logic [DW-1:0]                  div_num [NCH];
    logic [DW-1:0]                  div_den;
    logic [NCH-1:0]                 div_busy;
    logic [NCH-1:0]                 div_done;
    logic [DW-1:0]                  div_quot [NCH];

    always_comb
    begin
        if (sw_reg == '0)
            eff_w = CWW'(1);
        else if (32'(sw_reg) > 32'(MAX_WIDTH))
            eff_w = CWW'(MAX_WIDTH);
        else
            eff_w = CWW'(sw_reg);

        if (sh_reg == '0)
            eff_h = RWW'(1);
        else if (32'(sh_reg) > 32'(MAX_HEIGHT))
            eff_h = RWW'(MAX_HEIGHT);
        else
            eff_h = RWW'(sh_reg);

        if (tw_reg == '0)
            eff_tw = CWW'(1);
        else if (32'(tw_reg) > 32'(eff_w))
            eff_tw = eff_w;
        else
            eff_tw = CWW'(tw_reg);

        if (th_reg == '0)
            eff_th = RWW'(1);
        else if (32'(th_reg) > 32'(eff_h))
            eff_th = eff_h;
        else
            eff_th = RWW'(th_reg);
    end

    assign sc_inc   = sc_reg + CWW'(1);
    assign sr_inc   = sr_reg + RWW'(1);
    assign mem_addr = sc_reg[AW-1:0];
    assign col_prod = BW'(tc_reg + CWW'(1)) * BW'(eff_w);
    assign row_prod = BW'(tr_reg + RWW'(1)) * BW'(eff_h);
    assign n_full   = NW'(rbe_reg - rbs_reg) * NW'(cbe_reg - cbs_reg);

    always_comb
    begin
        for (int k = 0; k < NCH; k++)
        begin
            col_sum[k] = (first_row_reg ? '0 : mem_rdata_reg[k*SW +: SW])
                         + SW'(pix_reg[k]);
            mem_wdata[k*SW +: SW] = col_sum[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
            mem_rdata_reg <= mem[mem_addr];
        if (state_reg == S_MOD)
            mem[mem_addr] <= mem_wdata;
    end

    assign div_start = (state_reg == S_BDIV) || (state_reg == S_ODIV);
    assign div_den   = (state_reg == S_BDIV) ? bden_reg : n_reg;

    always_comb
    begin
        for (int k = 0; k < NCH; k++)
            div_num[k] = (state_reg == S_BDIV) ? prod_reg : bin_sum_reg[k];
    end

    for (genvar g = 0; g < NCH; g++)
    begin : g_div
        bfid_divider u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend (div_num[g]),
            .divisor  (div_den),
            .busy     (div_busy[g]),
            .done     (div_done[g]),
            .quotient (div_quot[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            sw_reg          <= bfid_pkg::CFG_W'(1);
            sh_reg          <= bfid_pkg::CFG_W'(1);
            tw_reg          <= bfid_pkg::CFG_W'(1);
            th_reg          <= bfid_pkg::CFG_W'(1);
            sc_reg          <= '0;
            tc_reg          <= '0;
            cbs_reg         <= '0;
            cbe_reg         <= CWW'(1);
            sr_reg          <= '0;
            tr_reg          <= '0;
            rbs_reg         <= '0;
            rbe_reg         <= RWW'(1);
            restart_req_reg <= 1'b0;
            pend_row_reg    <= 1'b0;
            pend_col_reg    <= 1'b0;
            cont_read_reg   <= 1'b0;
            job_row_reg     <= 1'b0;
            first_row_reg   <= 1'b0;
            last_row_reg    <= 1'b0;
            prod_reg        <= '0;
            bden_reg        <= '0;
            n_reg           <= '0;
            out_valid_reg   <= 1'b0;
            eor_reg         <= 1'b0;
            eof_reg         <= 1'b0;
            for (int k = 0; k < NCH; k++)
            begin
                pix_reg[k]     <= '0;
                bin_sum_reg[k] <= '0;
                out_pix_reg[k] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (restart_req_reg)
                    begin
                        restart_req_reg <= 1'b0;
                        sc_reg          <= '0;
                        tc_reg          <= '0;
                        cbs_reg         <= '0;
                        sr_reg          <= '0;
                        tr_reg          <= '0;
                        rbs_reg         <= '0;
                        pend_row_reg    <= 1'b1;
                        pend_col_reg    <= 1'b1;
                        cont_read_reg   <= 1'b0;
                        state_reg       <= S_JOB;
                    end
                    else if (in_valid)
                    begin
                        pix_reg[0] <= in_red;
                        pix_reg[1] <= in_green;
                        pix_reg[2] <= in_blue;
                        pix_reg[3] <= in_alpha;
                        if (start_of_frame)
                        begin
                            sc_reg        <= '0;
                            tc_reg        <= '0;
                            cbs_reg       <= '0;
                            sr_reg        <= '0;
                            tr_reg        <= '0;
                            rbs_reg       <= '0;
                            pend_row_reg  <= 1'b1;
                            pend_col_reg  <= 1'b1;
                            cont_read_reg <= 1'b1;
                            state_reg     <= S_JOB;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end

                S_JOB:
                begin
                    if (pend_row_reg)
                    begin
                        pend_row_reg <= 1'b0;
                        job_row_reg  <= 1'b1;
                        prod_reg     <= DW'(row_prod);
                        bden_reg     <= DW'(eff_th);
                        state_reg    <= S_BDIV;
                    end
                    else if (pend_col_reg)
                    begin
                        pend_col_reg <= 1'b0;
                        job_row_reg  <= 1'b0;
                        prod_reg     <= DW'(col_prod);
                        bden_reg     <= DW'(eff_tw);
                        state_reg    <= S_BDIV;
                    end
                    else
                    begin
                        state_reg <= cont_read_reg ? S_READ : S_IDLE;
                    end
                end

                S_BDIV:
                begin
                    state_reg <= S_BWAIT;
                end

                S_BWAIT:
                begin
                    if (div_done[0])
                    begin
                        if (job_row_reg)
                            rbe_reg <= div_quot[0][RWW-1:0];
                        else
                            cbe_reg <= div_quot[0][CWW-1:0];
                        state_reg <= S_JOB;
                    end
                end

                S_READ:
                begin
                    first_row_reg <= (sr_reg == rbs_reg);
                    last_row_reg  <= (sr_inc == rbe_reg);
                    if (sc_reg == cbs_reg)
                    begin
                        for (int k = 0; k < NCH; k++)
                            bin_sum_reg[k] <= '0;
                    end
                    state_reg <= S_MOD;
                end

                S_MOD:
                begin
                    if (last_row_reg)
                    begin
                        for (int k = 0; k < NCH; k++)
                            bin_sum_reg[k] <= bin_sum_reg[k] + col_sum[k];
                    end
                    if (last_row_reg && sc_inc == cbe_reg)
                    begin
                        n_reg     <= (n_full == '0) ? DW'(1) : DW'(n_full);
                        state_reg <= S_ODIV;
                    end
                    else
                    begin
                        state_reg <= S_ADV;
                    end
                end

                S_ODIV:
                begin
                    state_reg <= S_OWAIT;
                end

                S_OWAIT:
                begin
                    if (div_done[0])
                        state_reg <= S_OPUT;
                end

                S_OPUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        for (int k = 0; k < NCH; k++)
                            out_pix_reg[k] <= div_quot[k][bfid_pkg::PIX_W-1:0];
                        eor_reg       <= (tc_reg + CWW'(1) == eff_tw);
                        eof_reg       <= (tc_reg + CWW'(1) == eff_tw)
                                         && (tr_reg + RWW'(1) == eff_th);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_ADV;
                    end
                end

                S_ADV:
                begin
                    cont_read_reg <= 1'b0;
                    if (sc_inc >= eff_w)
                    begin
                        sc_reg       <= '0;
                        tc_reg       <= '0;
                        cbs_reg      <= '0;
                        pend_col_reg <= 1'b1;
                        state_reg    <= S_JOB;
                        if (sr_inc >= eff_h)
                        begin
                            sr_reg       <= '0;
                            tr_reg       <= '0;
                            rbs_reg      <= '0;
                            pend_row_reg <= 1'b1;
                        end
                        else
                        begin
                            sr_reg <= sr_inc;
                            if (sr_inc >= rbe_reg)
                            begin
                                tr_reg       <= tr_reg + RWW'(1);
                                rbs_reg      <= rbe_reg;
                                pend_row_reg <= 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        sc_reg <= sc_inc;
                        if (sc_inc >= cbe_reg)
                        begin
                            tc_reg       <= tc_reg + CWW'(1);
                            cbs_reg      <= cbe_reg;
                            pend_col_reg <= 1'b1;
                            state_reg    <= S_JOB;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (cfg_we)
            begin
                restart_req_reg <= 1'b1;
                unique case (cfg_index)
                    bfid_pkg::REG_SOURCE_WIDTH:  sw_reg <= cfg_data;
                    bfid_pkg::REG_SOURCE_HEIGHT: sh_reg <= cfg_data;
                    bfid_pkg::REG_TARGET_WIDTH:  tw_reg <= cfg_data;
                    bfid_pkg::REG_TARGET_HEIGHT: th_reg <= cfg_data;
                    default:                     sw_reg <= sw_reg;
                endcase
            end
        end
    end

    assign in_stall     = !((state_reg == S_IDLE) && !restart_req_reg);
    assign out_valid    = out_valid_reg;
    assign out_red      = out_pix_reg[0];
    assign out_green    = out_pix_reg[1];
    assign out_blue     = out_pix_reg[2];
    assign out_alpha    = out_pix_reg[3];
    assign end_of_row   = eor_reg;
    assign end_of_frame = eof_reg;

`ifndef SYNTHESIS
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted on two consecutive cycles");

    a_column_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !restart_req_reg) |-> (sc_reg < eff_w))
        else $error("source column outside the image while idle");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy[0])
        else $error("divider started while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OPUT && out_valid_reg && out_stall) |=> (state_reg == S_OPUT))
        else $error("result overwrote a pending item");
`endif

endmodule

`default_nettype wire
